[design/spq_pkg.sv]
// Shared types and codes of the stable priority queue with bypass.
package spq_pkg;

  // Insert or take, carried in the operation field.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_GIVEN    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Ring numbering: ring 0 is the bypass FIFO, rings 1 to 5 hold one priority each.
  localparam int          NUM_RINGS    = 6;
  localparam logic [2:0]  RING_FIFO    = 3'd0;
  localparam logic [2:0]  MIN_PRIORITY = 3'd1;
  localparam logic [2:0]  MAX_PRIORITY = 3'd5;

  // Widths of the item fields.
  localparam int TAG_W  = 16;
  localparam int PRIO_W = 3;

  // Decision that the ring bookkeeping hands to the datapath for one word.
  typedef struct packed {
    logic [1:0]        status;
    logic              from_sorted;
    logic [PRIO_W-1:0] prio;
    logic              rd;
  } spq_decision_t;

  // Sequencer states.
  typedef enum logic {
    SPQ_IDLE,
    SPQ_READ
  } spq_state_t;

endpackage

[design/spq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/spq_ring_ctrl.sv]
// Head, tail and count bookkeeping of the six rings that share the entry RAM.
module spq_ring_ctrl import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     acc,
  input  logic                                     operation,
  input  logic                                     has_ticket,
  input  logic [PRIO_W-1:0]                        priority_req,
  output logic                                     mem_we,
  output logic [$clog2(NUM_RINGS*QUEUE_DEPTH)-1:0] mem_waddr,
  output logic [$clog2(NUM_RINGS*QUEUE_DEPTH)-1:0] mem_raddr,
  output spq_decision_t                            decision
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_RINGS * QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] RING_SPAN = AW'(QUEUE_DEPTH);

  logic [PW-1:0] head_r [NUM_RINGS];
  logic [PW-1:0] tail_r [NUM_RINGS];
  logic [CW-1:0] cnt_r  [NUM_RINGS];
  logic [CW-1:0] total_r, total_nxt;

  logic [2:0]    ins_ring, take_ring;
  logic          sorted_any, any_avail, ins_full;
  logic          ins_ok, take_ok;
  logic [PW-1:0] tail_sel, head_sel;
  logic [CW+2:0] cnt_sum;

  // Clamp the requested priority and pick the ring for an insert.
  always_comb begin
    ins_ring = RING_FIFO;
    if (has_ticket) begin
      if (priority_req < MIN_PRIORITY) begin
        ins_ring = MIN_PRIORITY;
      end else if (priority_req > MAX_PRIORITY) begin
        ins_ring = MAX_PRIORITY;
      end else begin
        ins_ring = priority_req;
      end
    end
  end

  // Highest nonempty priority ring, else the FIFO ring.
  always_comb begin
    take_ring  = RING_FIFO;
    sorted_any = 1'b0;
    for (int r = 1; r < NUM_RINGS; r++) begin
      if (cnt_r[r] != '0) begin
        take_ring  = 3'(r);
        sorted_any = 1'b1;
      end
    end
  end

  assign any_avail = sorted_any || (cnt_r[RING_FIFO] != '0);
  assign ins_full  = has_ticket ? (total_r == CNT_FULL) : (cnt_r[RING_FIFO] == CNT_FULL);
  assign ins_ok    = acc && (operation == OP_INSERT) && !ins_full;
  assign take_ok   = acc && (operation == OP_TAKE) && any_avail;

  // Pointer of the selected rings.
  always_comb begin
    tail_sel = '0;
    head_sel = '0;
    for (int r = 0; r < NUM_RINGS; r++) begin
      if (ins_ring == 3'(r)) begin
        tail_sel = tail_r[r];
      end
      if (take_ring == 3'(r)) begin
        head_sel = head_r[r];
      end
    end
  end

  // Each ring occupies QUEUE_DEPTH consecutive words of the RAM.
  assign mem_we    = ins_ok;
  assign mem_waddr = AW'(ins_ring) * RING_SPAN + AW'(tail_sel);
  assign mem_raddr = AW'(take_ring) * RING_SPAN + AW'(head_sel);

  // Result codes for the current word.
  always_comb begin
    decision = '0;
    if (operation == OP_INSERT) begin
      decision.status = ins_full ? ST_FULL : ST_INSERTED;
    end else if (any_avail) begin
      decision.status      = ST_GIVEN;
      decision.from_sorted = sorted_any;
      decision.prio        = sorted_any ? take_ring : '0;
      decision.rd          = 1'b1;
    end else begin
      decision.status = ST_EMPTY;
    end
  end

  // Per-ring pointer and count registers.
  for (genvar g = 0; g < NUM_RINGS; g++) begin : g_ring
    logic hit_ins, hit_take;
    assign hit_ins  = ins_ok && (ins_ring == 3'(g));
    assign hit_take = take_ok && (take_ring == 3'(g));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r[g] <= '0;
        tail_r[g] <= '0;
        cnt_r[g]  <= '0;
      end else begin
        if (hit_ins) begin
          tail_r[g] <= (tail_r[g] == PTR_LAST) ? '0 : tail_r[g] + 1'b1;
          cnt_r[g]  <= cnt_r[g] + 1'b1;
        end else if (hit_take) begin
          head_r[g] <= (head_r[g] == PTR_LAST) ? '0 : head_r[g] + 1'b1;
          cnt_r[g]  <= cnt_r[g] - 1'b1;
        end
      end
    end
  end

  // Total fill of the sorted store.
  always_comb begin
    total_nxt = total_r;
    if (ins_ok && has_ticket) begin
      total_nxt = total_r + 1'b1;
    end else if (take_ok && sorted_any) begin
      total_nxt = total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Sum of the priority ring counts, for checking.
  always_comb begin
    cnt_sum = '0;
    for (int r = 1; r < NUM_RINGS; r++) begin
      cnt_sum = cnt_sum + (CW+3)'(cnt_r[r]);
    end
  end

  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sum == (CW+3)'(total_r))
    else $error("sorted total differs from sum of ring counts");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_FULL)
    else $error("sorted store over capacity");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[RING_FIFO] <= CNT_FULL)
    else $error("bypass FIFO over capacity");

endmodule

[design/stable_priority_queue_with_bypass_core.sv]
// Top level of the stable priority queue with bypass FIFO.
// Holds up to QUEUE_DEPTH ticketed entries in priority order (5 highest, equal priorities in
// arrival order) and up to QUEUE_DEPTH unticketed entries in a plain FIFO; a take returns the
// best ticketed entry, or the FIFO head when no ticketed entry is held. All tags live in one
// RAM of 6 * QUEUE_DEPTH words split into six rings, one per priority plus the FIFO. An insert,
// a dropped insert and a take on empty stores are answered when accepted; a take that returns
// an entry passes through SPQ_READ while the registered read port of the entry RAM returns its
// tag, and the input is held off in that state. One result word is produced per input word, held
// in an output register until taken; outside SPQ_READ the next input word is accepted as soon
// as that register is free or being emptied. No clearing pass is needed after reset.
module stable_priority_queue_with_bypass_core import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [2:0] priority_req, [18:3] tag, [23:19] zero
  input  logic [1:0]  in_tuser,   // [0] operation, [1] has_ticket
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] out_priority, [18:3] out_tag, [23:19] zero
  output logic [2:0]  out_tuser   // [1:0] status, [2] from_sorted
);

  localparam int AW = $clog2(NUM_RINGS * QUEUE_DEPTH);

  spq_state_t    state_r, state_nxt;
  spq_decision_t decision;
  logic          in_acc, out_free;
  logic          load_now, load_tag;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [TAG_W-1:0] mem_rdata;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_from_r;
  logic [PRIO_W-1:0] out_prio_r;
  logic [TAG_W-1:0]  out_tag_r;

  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;

  // Ring bookkeeping.
  spq_ring_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ring_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .operation    (in_tuser[0]),
    .has_ticket   (in_tuser[1]),
    .priority_req (in_tdata[2:0]),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_raddr    (mem_raddr),
    .decision     (decision)
  );

  // Shared entry RAM.
  spq_ram #(
    .WIDTH(TAG_W),
    .DEPTH(NUM_RINGS * QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_tdata[18:3]),
    .re    (in_acc && decision.rd),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SPQ_IDLE: begin
        if (in_acc && decision.rd) begin
          state_nxt = SPQ_READ;
        end
      end
      SPQ_READ: begin
        state_nxt = SPQ_IDLE;
      end
      default: begin
        state_nxt = SPQ_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    load_tag  = 1'b0;
    case (state_r)
      SPQ_IDLE: begin
        in_tready = out_free;
      end
      SPQ_READ: begin
        load_tag = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign load_now = in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SPQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_tag || (load_now && !decision.rd)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload; a given entry's tag is loaded from the RAM's registered read port in SPQ_READ.
  always_ff @(posedge clk) begin
    if (load_now) begin
      out_status_r <= decision.status;
      out_from_r   <= decision.from_sorted;
      out_prio_r   <= decision.prio;
      out_tag_r    <= '0;
    end else if (load_tag) begin
      out_tag_r    <= mem_rdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_tag_r, out_prio_r};
  assign out_tuser  = {out_from_r, out_status_r};

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SPQ_READ) |-> !out_valid_r)
    else $error("output register busy while RAM data returns");

  a_read_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && decision.rd) |=> (state_r == SPQ_READ) && !in_tready)
    else $error("take did not enter the read cycle");

  a_read_gives_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SPQ_READ) |=> out_valid_r && (out_status_r == ST_GIVEN))
    else $error("read cycle did not present a given entry");

endmodule
